FILE: src/lcgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgr_pkg
// Types and constants shared by the ranged random integer generator.
// ----------------------------------------------------------------------------
package lcgr_pkg;

   // Generator recurrence: state = LcgMul * state + LcgAdd (mod 2^32).
   localparam int unsigned StateWidth = 32;
   localparam logic [StateWidth-1:0] LcgMul = 32'd214013;
   localparam logic [StateWidth-1:0] LcgAdd = 32'd2531011;

   // One draw is bits 30..16 of the new state.
   localparam int unsigned DrawShift  = 16;
   localparam int unsigned DrawBits   = 15;

   // A combined draw holds two draws, the second one shifted up by DrawShift.
   localparam int unsigned DrawWidth  = DrawShift + DrawBits;

   // Range width |high - low + 1| needs one bit more than a data word.
   localparam int unsigned ModWidth   = StateWidth + 1;
   localparam int unsigned CountWidth = $clog2(DrawWidth);

   // Threshold on |high - low| at or above which a second draw is taken.
   localparam logic [ModWidth-1:0] WideLimitPos = 33'h0_0000_8000;
   localparam logic [ModWidth-1:0] WideLimitNeg = 33'h1_FFFF_8000;

   // Controls from the sequencer to the generator.
   typedef struct packed {
      logic                  load;
      logic                  advance;
      logic [StateWidth-1:0] seed;
   } lcgr_lcg_ctl_type;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } lcgr_div_sts_type;

endpackage

FILE: src/lcgr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgr_req_if
// Request channel: one item carries the lower and upper bound of a range.
// ----------------------------------------------------------------------------
interface lcgr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] range_low;
   logic signed [31:0] range_high;

   modport source (output valid, output range_low, output range_high, input ready);
   modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

FILE: src/lcgr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgr_rsp_if
// Response channel: one item carries the random value and the range error flag.
// ----------------------------------------------------------------------------
interface lcgr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] random_value;
   logic               range_error;

   modport source (output valid, output random_value, output range_error, input ready);
   modport sink   (input valid, input random_value, input range_error, output ready);
endinterface

FILE: src/lcgr_lcg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgr_lcg
// Linear congruential generator state with seed load and single-step advance.
// ----------------------------------------------------------------------------
module lcgr_lcg
   import lcgr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  lcgr_lcg_ctl_type      ctl,
   output logic [DrawBits-1:0]   draw
);

   logic [StateWidth-1:0] state_ff;
   logic [StateWidth-1:0] step;
   logic [StateWidth-1:0] state_in;

   // Next state of the recurrence, truncated to 32 bits.
   always_comb begin
      step = StateWidth'(state_ff * LcgMul) + LcgAdd;
      if (ctl.load) begin
         state_in = ctl.seed;
      end else if (ctl.advance) begin
         state_in = step;
      end else begin
         state_in = state_ff;
      end
   end

   // The draw is taken from the state being produced by this advance.
   assign draw = step[DrawShift +: DrawBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/lcgr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgr_div
// Radix-2 restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lcgr_div
   import lcgr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DrawWidth-1:0]  dividend,
   input  logic [ModWidth-1:0]   divisor,
   output lcgr_div_sts_type      sts,
   output logic [ModWidth-1:0]   remainder
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CountWidth-1:0] count_ff;
   logic [DrawWidth-1:0]  dividend_ff;
   logic [ModWidth-1:0]   divisor_ff;
   logic [ModWidth-1:0]   rem_ff;

   logic [ModWidth:0]     trial;
   logic [ModWidth:0]     trial_sub;
   logic [ModWidth-1:0]   rem_in;

   // Shift in the next dividend bit and subtract the divisor when it fits.
   always_comb begin
      trial     = {rem_ff, dividend_ff[DrawWidth-1]};
      trial_sub = trial - {1'b0, divisor_ff};
      if (trial >= {1'b0, divisor_ff}) begin
         rem_in = trial_sub[ModWidth-1:0];
      end else begin
         rem_in = trial[ModWidth-1:0];
      end
   end

   // Control: start loads the operands, then one step per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + CountWidth'(1);
            if (count_ff == CountWidth'(DrawWidth - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff      <= '0;
         dividend_ff <= dividend;
         divisor_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff      <= rem_in;
         dividend_ff <= {dividend_ff[DrawWidth-2:0], 1'b0};
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/lcg_ranged_random_integer_top.sv
`timescale 1ns / 1ps
// Per item the sequencer takes one draw, or two for a wide range, then runs the
// 31-step remainder unit and loads the result; a zero range width skips the division.
// One item is in work at a time, taken the cycle after the previous result is loaded;
// a result that waits for the consumer holds the next item back.
// Reset (synchronous, active high) clears the generator state to 0 and empties the
// output register.
// ----------------------------------------------------------------------------
// lcg_ranged_random_integer_top
// Ranged random integer from a 32-bit linear congruential generator, reduced by
// a shared bit-serial remainder unit under a small sequencer.
// ----------------------------------------------------------------------------
module lcg_ranged_random_integer_top
   import lcgr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lcgr_req_if.sink              req_bus,
   lcgr_rsp_if.source            rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [StateWidth-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW1,
      ST_DRAW2,
      ST_START,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   logic signed [31:0]     low_ff;
   logic signed [31:0]     high_ff;
   logic [DrawWidth-1:0]   draw_ff;
   logic [ModWidth-1:0]    modulus_ff;
   logic                   error_ff;
   logic                   rsp_valid_ff;
   logic signed [31:0]     rsp_value_ff;
   logic                   rsp_error_ff;

   lcgr_lcg_ctl_type       lcg_ctl;
   logic [DrawBits-1:0]    lcg_draw;
   lcgr_div_sts_type       div_sts;
   logic [ModWidth-1:0]    div_rem;
   logic                   div_start;

   logic [ModWidth-1:0]    diff;
   logic                   wide;
   logic [ModWidth-1:0]    modulus;
   logic                   zero_width;
   logic                   accept;
   logic                   out_free;
   logic [31:0]            sum;

   // Range arithmetic on the held bounds, 33-bit two's complement.
   always_comb begin
      diff       = {high_ff[31], high_ff} - {low_ff[31], low_ff};
      zero_width = (diff == '1);
      if (diff[ModWidth-1]) begin
         wide    = (diff <= WideLimitNeg);
         modulus = ~diff;
      end else begin
         wide    = (diff >= WideLimitPos);
         modulus = diff + ModWidth'(1);
      end
   end

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign sum      = div_rem[31:0] + low_ff;

   // Generator control: seed writes reload the state, draw states advance it.
   always_comb begin
      lcg_ctl.load    = csr_write_enable;
      lcg_ctl.seed    = csr_write_data;
      lcg_ctl.advance = (state_ff == ST_DRAW1) || (state_ff == ST_DRAW2);
   end

   assign div_start = (state_ff == ST_START);

   lcgr_lcg u_lcg (
      .clock (clock),
      .reset (reset),
      .ctl   (lcg_ctl),
      .draw  (lcg_draw)
   );

   lcgr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (draw_ff),
      .divisor   (modulus_ff),
      .sts       (div_sts),
      .remainder (div_rem)
   );

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_DRAW1;
               end
            end
            ST_DRAW1: begin
               if (zero_width) begin
                  state_ff <= ST_FINISH;
               end else if (wide) begin
                  state_ff <= ST_DRAW2;
               end else begin
                  state_ff <= ST_START;
               end
            end
            ST_DRAW2: begin
               state_ff <= ST_START;
            end
            ST_START: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_sts.done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Item payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         low_ff  <= req_bus.range_low;
         high_ff <= req_bus.range_high;
      end
      if (state_ff == ST_DRAW1) begin
         draw_ff    <= {{(DrawWidth - DrawBits){1'b0}}, lcg_draw};
         modulus_ff <= modulus;
         error_ff   <= zero_width;
      end else if (state_ff == ST_DRAW2) begin
         draw_ff    <= draw_ff | {lcg_draw, {DrawShift{1'b0}}};
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_error_ff <= error_ff;
         rsp_value_ff <= error_ff ? low_ff : $signed(sum);
      end
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.random_value = rsp_value_ff;
   assign rsp_bus.range_error  = rsp_error_ff;

endmodule

FILE: src/lcgr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgr_checker
// Port-level checks of the ranged random integer generator, bound to the top.
// ----------------------------------------------------------------------------
module lcgr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready
);

   // The output register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A result waiting for the consumer stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Only one item is in work: an accepted item blocks the next one.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A new result is only loaded while the block was busy with an item.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without an item in work");

endmodule

bind lcg_ranged_random_integer_top lcgr_checker u_lcgr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);
